// File: design/clamped_motion_integrator_assert.svh
// assertion macros used by the motion integrator top level
`ifndef CLAMPED_MOTION_INTEGRATOR_ASSERT_SVH
`define CLAMPED_MOTION_INTEGRATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define CMI_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define CMI_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define CMI_ASSERT_IMP(label, clk, rst_n, cond, prop, msg)
`define CMI_ASSERT_NXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

// File: design/cmi_pkg.sv
// types and constants for the clamped motion integrator
package cmi_pkg;

  localparam int CFG_ADDR_W = 4;

  // operation codes
  localparam logic [2:0] OP_TICK_ABS    = 3'd0;
  localparam logic [2:0] OP_TICK_PARENT = 3'd1;
  localparam logic [2:0] OP_TICK_CAMERA = 3'd2;
  localparam logic [2:0] OP_PUBLISH     = 3'd3;
  localparam logic [2:0] OP_LOAD        = 3'd4;

  // register indexes
  localparam logic [1:0] REG_ACCEL_X     = 2'd0;
  localparam logic [1:0] REG_ACCEL_Y     = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED_X = 2'd2;
  localparam logic [1:0] REG_MAX_SPEED_Y = 2'd3;

  // speed limit value that turns the clamp off
  localparam logic signed [31:0] NO_LIMIT = 32'sh8000_0000;

  typedef struct packed {
    logic        [2:0]  operation;
    logic signed [31:0] parent_pos_x;
    logic signed [31:0] parent_pos_y;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
  } out_rsp_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] max_speed_x;
    logic signed [31:0] max_speed_y;
  } cfg_t;

endpackage

// File: design/cmi_regs.sv
// apb register file holding acceleration and speed limits
module cmi_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmi_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output cmi_pkg::cfg_t                 cfg
);
  import cmi_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_ACCEL_X:     cfg_nxt.accel_x     = pwdata;
        REG_ACCEL_Y:     cfg_nxt.accel_y     = pwdata;
        REG_MAX_SPEED_X: cfg_nxt.max_speed_x = pwdata;
        REG_MAX_SPEED_Y: cfg_nxt.max_speed_y = pwdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_x     <= '0;
      cfg_r.accel_y     <= '0;
      cfg_r.max_speed_x <= NO_LIMIT;
      cfg_r.max_speed_y <= NO_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[3:2])
      REG_ACCEL_X:     prdata = cfg_r.accel_x;
      REG_ACCEL_Y:     prdata = cfg_r.accel_y;
      REG_MAX_SPEED_X: prdata = cfg_r.max_speed_x;
      REG_MAX_SPEED_Y: prdata = cfg_r.max_speed_y;
    endcase
  end

endmodule

// File: design/cmi_axis.sv
// one axis of the integrator: accelerate, clamp, then move
module cmi_axis (
  input  logic signed [31:0] pos_i,
  input  logic signed [31:0] vel_i,
  input  logic signed [31:0] accel_i,
  input  logic signed [31:0] max_speed_i,
  output logic signed [31:0] pos_o,
  output logic signed [31:0] vel_o
);
  import cmi_pkg::*;

  logic signed [31:0] vel_acc;
  logic signed [31:0] neg_lim;

  assign vel_acc = vel_i + accel_i;
  assign neg_lim = -max_speed_i;

  // clamp against the limit, or its negation at zero and below
  always_comb begin
    vel_o = vel_acc;
    if (max_speed_i != NO_LIMIT) begin
      if (vel_acc > 32'sd0) begin
        if (vel_acc > max_speed_i) vel_o = max_speed_i;
      end else begin
        if (neg_lim > vel_acc) vel_o = neg_lim;
      end
    end
  end

  assign pos_o = pos_i + vel_o;

endmodule

// File: design/clamped_motion_integrator.sv
// top level of the clamped motion integrator
// Takes one request per clock while out_ready does not hold back the result
// register. A request is latched into an input register, worked against the
// stored position and velocity (add acceleration, clamp, add velocity) as it
// moves on, and the result is captured in the output register together with
// the new state. The rate is set by the state feedback loop: the 32-bit
// velocity add, the clamp compares and the position add close with no register
// between them. Configuration writes take effect from the next request
// onward.
`include "clamped_motion_integrator_assert.svh"
module clamped_motion_integrator #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmi_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cmi_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cmi_pkg::out_rsp_t             out_data
);
  import cmi_pkg::*;

  cfg_t     cfg;
  in_req_t  stg_data_r;
  logic     stg_valid_r;
  out_rsp_t out_data_r;
  out_rsp_t out_data_nxt;
  logic     out_valid_r;
  logic     advance;
  logic     integrate;
  logic     any_motion;

  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic signed [31:0] pos_x_nxt, pos_y_nxt, vel_x_nxt, vel_y_nxt;
  logic signed [31:0] int_pos_x, int_pos_y, int_vel_x, int_vel_y;
  logic signed [31:0] par_sum_x, par_sum_y;
  logic signed [31:0] scr_x, scr_y;

  cmi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: input register refills as the held request moves on
  assign advance   = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_data_r <= in_data;
    end
  end

  // integration datapath per axis
  cmi_axis u_axis_x (
    .pos_i       (pos_x_r),
    .vel_i       (vel_x_r),
    .accel_i     (cfg.accel_x),
    .max_speed_i (cfg.max_speed_x),
    .pos_o       (int_pos_x),
    .vel_o       (int_vel_x)
  );

  cmi_axis u_axis_y (
    .pos_i       (pos_y_r),
    .vel_i       (vel_y_r),
    .accel_i     (cfg.accel_y),
    .max_speed_i (cfg.max_speed_y),
    .pos_o       (int_pos_y),
    .vel_o       (int_vel_y)
  );

  // parent mode only moves an object that has some motion
  assign any_motion = (vel_x_r != '0) || (vel_y_r != '0) ||
                      (cfg.accel_x != '0) || (cfg.accel_y != '0);

  // next state selection by operation
  always_comb begin
    integrate = 1'b0;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    vel_x_nxt = vel_x_r;
    vel_y_nxt = vel_y_r;
    unique case (stg_data_r.operation)
      OP_TICK_ABS:    integrate = 1'b1;
      OP_TICK_PARENT: integrate = any_motion;
      OP_TICK_CAMERA: integrate = 1'b1;
      default:        integrate = 1'b0;
    endcase
    if (stg_data_r.operation == OP_LOAD) begin
      pos_x_nxt = stg_data_r.load_pos_x;
      pos_y_nxt = stg_data_r.load_pos_y;
      vel_x_nxt = stg_data_r.load_vel_x;
      vel_y_nxt = stg_data_r.load_vel_y;
    end else if (integrate) begin
      pos_x_nxt = int_pos_x;
      pos_y_nxt = int_pos_y;
      vel_x_nxt = int_vel_x;
      vel_y_nxt = int_vel_y;
    end
  end

  // screen coordinate per publish mode
  assign par_sum_x = pos_x_nxt + stg_data_r.parent_pos_x;
  assign par_sum_y = pos_y_nxt + stg_data_r.parent_pos_y;

  always_comb begin
    unique case (stg_data_r.operation)
      OP_TICK_PARENT: begin
        scr_x = par_sum_x >>> FRACTION_BITS;
        scr_y = par_sum_y >>> FRACTION_BITS;
      end
      OP_TICK_CAMERA: begin
        scr_x = (pos_x_nxt >>> FRACTION_BITS) - (stg_data_r.camera_x >>> FRACTION_BITS);
        scr_y = (pos_y_nxt >>> FRACTION_BITS) - (stg_data_r.camera_y >>> FRACTION_BITS);
      end
      default: begin
        scr_x = pos_x_nxt >>> FRACTION_BITS;
        scr_y = pos_y_nxt >>> FRACTION_BITS;
      end
    endcase
  end

  always_comb begin
    out_data_nxt.screen_x   = scr_x[15:0];
    out_data_nxt.screen_y   = scr_y[15:0];
    out_data_nxt.position_x = pos_x_nxt;
    out_data_nxt.position_y = pos_y_nxt;
    out_data_nxt.velocity_x = vel_x_nxt;
    out_data_nxt.velocity_y = vel_y_nxt;
  end

  // object state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
    end else if (advance) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      vel_x_r <= vel_x_nxt;
      vel_y_r <= vel_y_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  `CMI_ASSERT_IMP(a_stg_hold, clk, rst_n, stg_valid_r && !advance, !in_ready,
    "held request would be overwritten")
  `CMI_ASSERT_NXT(a_rsp_state, clk, rst_n, advance,
    out_valid_r && out_data_r.position_x == pos_x_r && out_data_r.velocity_y == vel_y_r,
    "result does not match stored state")
  `CMI_ASSERT_NXT(a_publish_hold, clk, rst_n,
    advance && stg_data_r.operation == OP_PUBLISH,
    $stable(pos_x_r) && $stable(vel_x_r) && $stable(pos_y_r) && $stable(vel_y_r),
    "publish request changed state")
  `CMI_ASSERT_NXT(a_load_state, clk, rst_n, advance && stg_data_r.operation == OP_LOAD,
    vel_x_r == $past(stg_data_r.load_vel_x) && pos_y_r == $past(stg_data_r.load_pos_y),
    "load request did not set state")

endmodule

// File: verif/clamped_motion_integrator_tb.sv
// self-checking testbench for the clamped motion integrator
module clamped_motion_integrator_tb;
  import cmi_pkg::*;

  localparam int FRACTION_BITS = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 64;
  localparam int PRESSURE_ITEMS = 30;

  // spare operation codes, handled as publish only
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // tracks position and velocity and holds the results still owed by the block
  class motion_scoreboard;
    logic signed [31:0] accel_x, accel_y, max_speed_x, max_speed_y;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    out_rsp_t owed_q[$];
    int mismatches, results_checked, requests_noted;
    int clamp_hits, parent_holds;
    int op_count[8];

    function new();
      accel_x = '0;
      accel_y = '0;
      max_speed_x = NO_LIMIT;
      max_speed_y = NO_LIMIT;
      pos_x = '0;
      pos_y = '0;
      vel_x = '0;
      vel_y = '0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_ACCEL_X:     accel_x = value;
        REG_ACCEL_Y:     accel_y = value;
        REG_MAX_SPEED_X: max_speed_x = value;
        REG_MAX_SPEED_Y: max_speed_y = value;
        default: ;
      endcase
    endfunction

    // positive speed capped at the limit, zero or below held at the negated limit
    function logic signed [31:0] clamp_speed(logic signed [31:0] v, logic signed [31:0] lim);
      logic signed [31:0] neg_lim;
      neg_lim = -lim;
      if (lim == NO_LIMIT) return v;
      if (v > 0) begin
        if (v > lim) return lim;
      end else if (neg_lim > v) begin
        return neg_lim;
      end
      return v;
    endfunction

    // one euler step: accelerate, clamp, move
    function void advance();
      logic signed [31:0] raw_x, raw_y;
      raw_x = vel_x + accel_x;
      raw_y = vel_y + accel_y;
      vel_x = clamp_speed(raw_x, max_speed_x);
      vel_y = clamp_speed(raw_y, max_speed_y);
      if (vel_x != raw_x) clamp_hits++;
      if (vel_y != raw_y) clamp_hits++;
      pos_x = pos_x + vel_x;
      pos_y = pos_y + vel_y;
    endfunction

    function void note_request(in_req_t r);
      out_rsp_t e;
      logic signed [31:0] sx, sy, other_x, other_y;
      requests_noted++;
      op_count[r.operation]++;
      case (r.operation)
        OP_TICK_ABS: begin
          advance();
          sx = pos_x >>> FRACTION_BITS;
          sy = pos_y >>> FRACTION_BITS;
        end
        OP_TICK_PARENT: begin
          if (vel_x != 0 || vel_y != 0 || accel_x != 0 || accel_y != 0) advance();
          else parent_holds++;
          other_x = pos_x + $signed(r.parent_pos_x);
          other_y = pos_y + $signed(r.parent_pos_y);
          sx = other_x >>> FRACTION_BITS;
          sy = other_y >>> FRACTION_BITS;
        end
        OP_TICK_CAMERA: begin
          advance();
          other_x = r.camera_x;
          other_y = r.camera_y;
          sx = (pos_x >>> FRACTION_BITS) - (other_x >>> FRACTION_BITS);
          sy = (pos_y >>> FRACTION_BITS) - (other_y >>> FRACTION_BITS);
        end
        OP_LOAD: begin
          pos_x = r.load_pos_x;
          pos_y = r.load_pos_y;
          vel_x = r.load_vel_x;
          vel_y = r.load_vel_y;
          sx = pos_x >>> FRACTION_BITS;
          sy = pos_y >>> FRACTION_BITS;
        end
        default: begin
          sx = pos_x >>> FRACTION_BITS;
          sy = pos_y >>> FRACTION_BITS;
        end
      endcase
      e.screen_x = sx[15:0];
      e.screen_y = sy[15:0];
      e.position_x = pos_x;
      e.position_y = pos_y;
      e.velocity_x = vel_x;
      e.velocity_y = vel_y;
      owed_q.push_back(e);
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t e;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: screen %h/%h pos %h/%h vel %h/%h",
                   got.screen_x, got.screen_y, got.position_x, got.position_y,
                   got.velocity_x, got.velocity_y);
        return;
      end
      e = owed_q.pop_front();
      results_checked++;
      if (got.screen_x !== e.screen_x || got.screen_y !== e.screen_y ||
          got.position_x !== e.position_x || got.position_y !== e.position_y ||
          got.velocity_x !== e.velocity_x || got.velocity_y !== e.velocity_y) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("mismatch on result %0d:", results_checked);
          $display("  expected screen %h/%h pos %h/%h vel %h/%h", e.screen_x, e.screen_y,
                   e.position_x, e.position_y, e.velocity_x, e.velocity_y);
          $display("  actual   screen %h/%h pos %h/%h vel %h/%h", got.screen_x,
                   got.screen_y, got.position_x, got.position_y, got.velocity_x,
                   got.velocity_y);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_rsp_t out_data;

  motion_scoreboard sb = new();
  int sent_count = 0;
  int idle_cycles = 0;
  bit want_long_stall = 1'b0;

  clamped_motion_integrator #(
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // monitor both channels at the clock edge and track progress
  always @(posedge clk) begin
    bit progress;
    progress = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_data);
        progress = 1'b1;
      end
      if (out_valid && out_ready) begin
        sb.check_response(out_data);
        progress = 1'b1;
      end
      if (psel && penable) progress = 1'b1;
      idle_cycles = progress ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on stalled progress
  initial begin : watchdog
    do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("no progress for %0d cycles", IDLE_LIMIT);
    $display("clamped_motion_integrator test failed");
    $finish;
  end

  // receiver: changing ready pattern plus on-demand long hold-off
  initial begin : receiver
    int mode, left, hold;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (want_long_stall) begin
        want_long_stall = 1'b0;
        hold = LONG_HOLD;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 9) < 3);
          default: out_ready <= (left % 4 == 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0001_0000;
      default: return 32'hffff_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return pick_extreme();
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  // speeds biased toward the current limit so the clamp fires often
  function automatic logic [31:0] rand_speed(logic [31:0] lim);
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return lim + $urandom_range(0, 8) - 4;
      3: return -lim + $urandom_range(0, 8) - 4;
      4: return pick_extreme();
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_accel();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return $urandom;
      2: return pick_extreme();
      default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [31:0] random_limit();
    case ($urandom_range(0, 7))
      0: return NO_LIMIT;
      1: return 32'h0;
      2: return $urandom;
      3: return 32'h7fff_ffff;
      4: return -$urandom_range(1, 32'h0004_0000);
      5: return 32'h8000_0001;
      default: return $urandom_range(1, 32'h0008_0000);
    endcase
  endfunction

  function automatic in_req_t random_request();
    in_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) r.operation = OP_TICK_ABS;
    else if (pick < 40) r.operation = OP_TICK_PARENT;
    else if (pick < 58) r.operation = OP_TICK_CAMERA;
    else if (pick < 70) r.operation = OP_PUBLISH;
    else if (pick < 88) r.operation = OP_LOAD;
    else r.operation = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
    r.parent_pos_x = rand_coord();
    r.parent_pos_y = rand_coord();
    r.camera_x = rand_coord();
    r.camera_y = rand_coord();
    r.load_pos_x = rand_coord();
    r.load_pos_y = rand_coord();
    r.load_vel_x = rand_speed(sb.max_speed_x);
    r.load_vel_y = rand_speed(sb.max_speed_y);
    // a resting object lets the parent mode skip its step
    if ($urandom_range(0, 3) == 0) begin
      r.load_vel_x = '0;
      r.load_vel_y = '0;
    end
    return r;
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(input in_req_t r);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [2:0] op, input logic [31:0] arg_x, arg_y);
    in_req_t r;
    r = random_request();
    r.operation = op;
    r.parent_pos_x = arg_x;
    r.parent_pos_y = arg_y;
    r.camera_x = arg_x;
    r.camera_y = arg_y;
    send_request(r);
  endtask

  task automatic send_load(input logic [31:0] px, py, vx, vy);
    in_req_t r;
    r = random_request();
    r.operation = OP_LOAD;
    r.load_pos_x = px;
    r.load_pos_y = py;
    r.load_vel_x = vx;
    r.load_vel_y = vy;
    send_request(r);
  endtask

  // stop sending and wait for every owed result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.results_checked < sent_count) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] ax, ay, mx, my);
    drain_results();
    write_register(REG_ACCEL_X, ax);
    write_register(REG_ACCEL_Y, ay);
    write_register(REG_MAX_SPEED_X, mx);
    write_register(REG_MAX_SPEED_Y, my);
  endtask

  // random bursts separated by random gaps, now and then a long one
  task automatic run_phase(input int items, input int max_gap);
    int burst;
    while (items > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > items) burst = items;
      repeat (burst) send_request(random_request());
      items -= burst;
      if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(20, 40));
      else if (max_gap > 0) pause_sender($urandom_range(0, max_gap));
    end
  endtask

  initial begin : stimulus
    int phase_idx;
    int max_gap;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: resting object, wraps, all operation codes
    send_op(OP_PUBLISH, 32'h0, 32'h0);
    send_op(OP_TICK_PARENT, 32'h7fff_ffff, 32'h8000_0000);
    send_op(OP_TICK_PARENT, 32'h8000_0000, 32'hffff_ffff);
    send_op(OP_TICK_ABS, 32'h0, 32'h0);
    send_load(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    send_op(OP_TICK_ABS, 32'h0, 32'h0);
    send_op(OP_TICK_CAMERA, 32'h8000_0000, 32'h7fff_ffff);
    send_op(OP_TICK_PARENT, 32'h7fff_ffff, 32'h0001_0000);
    send_op(OP_SPARE_5, 32'h0, 32'h0);
    send_op(OP_SPARE_6, 32'h0, 32'h0);
    send_op(OP_SPARE_7, 32'h0, 32'h0);
    send_load(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_op(OP_TICK_ABS, 32'h0, 32'h0);

    // clamp on both sides, zero speed takes the lower branch
    apply_config(32'h0001_0000, 32'hffff_0000, 32'h0003_0000, 32'h0003_0000);
    send_load(32'h0, 32'h0, 32'h0002_8000, 32'hfffd_8000);
    send_op(OP_TICK_ABS, 32'h0, 32'h0);
    send_op(OP_TICK_CAMERA, 32'hffff_8000, 32'h0001_8000);
    send_load(32'h0, 32'h0, 32'h0, 32'h0);
    send_op(OP_TICK_PARENT, 32'h0002_0000, 32'hfffe_0000);

    // negative limit applied literally, extreme acceleration
    apply_config(32'h8000_0000, 32'h7fff_ffff, 32'hfffe_0000, 32'h7fff_ffff);
    send_load(32'h1234_5678, 32'hedcb_a987, 32'h0000_0005, 32'h0);
    send_op(OP_TICK_ABS, 32'h0, 32'h0);
    send_op(OP_TICK_ABS, 32'h0, 32'h0);

    // zero limit and the most negative enabled limit
    apply_config(32'h0, 32'h0, 32'h0, 32'h8000_0001);
    send_load(32'h0, 32'h0, 32'h0001_0000, 32'h8000_0000);
    send_op(OP_TICK_ABS, 32'h0, 32'h0);
    send_op(OP_TICK_PARENT, 32'h4000_0000, 32'hc000_0000);

    // random phases, each under its own settings
    for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      case (phase_idx)
        0: apply_config(32'h0, 32'h0, NO_LIMIT, NO_LIMIT);
        1: apply_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        2: apply_config(32'h0, 32'h0, 32'h0002_0000, 32'h8000_0001);
        3: apply_config(32'h8000_0000, 32'h0000_0001, 32'h0, 32'hffff_0000);
        default: begin
          if (phase_idx % 4 == 0) apply_config(32'h0, 32'h0, random_limit(), random_limit());
          else apply_config(random_accel(), random_accel(), random_limit(), random_limit());
        end
      endcase
      max_gap = (phase_idx % 3 == 0) ? 0 : $urandom_range(2, 12);
      // hold the receiver off while the sender keeps pushing
      if (phase_idx == 5 || phase_idx == 9) begin
        want_long_stall = 1'b1;
        repeat (PRESSURE_ITEMS) send_request(random_request());
      end
      run_phase(PHASE_ITEMS, max_gap);
    end

    drain_results();
    repeat (3 * SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: tick %0d, parent %0d, camera %0d, publish %0d, load %0d",
             sb.requests_noted, sb.op_count[OP_TICK_ABS], sb.op_count[OP_TICK_PARENT],
             sb.op_count[OP_TICK_CAMERA], sb.op_count[OP_PUBLISH], sb.op_count[OP_LOAD]);
    $display("spare codes %0d, clamps %0d, parent holds %0d, results %0d, mismatches %0d",
             sb.op_count[OP_SPARE_5] + sb.op_count[OP_SPARE_6] + sb.op_count[OP_SPARE_7],
             sb.clamp_hits, sb.parent_holds, sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("clamped_motion_integrator test passed");
    end else begin
      $display("clamped_motion_integrator test failed");
    end
    $finish;
  end

endmodule
